// ===== src/ocr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Overcurrent relay package
// Shared types, codes and reset values for the feeder overcurrent relay.
// ----------------------------------------------------------------------------
package ocr_pkg;

  localparam int CurW   = 20;
  localparam int TimerW = 21;
  localparam int MultW  = 16;
  localparam int NumCh  = 4;
  localparam int ChW    = 2;

  typedef logic [CurW-1:0]   cur_t;
  typedef logic [TimerW-1:0] timer_t;

  localparam timer_t TimerMax = {TimerW{1'b1}};

  // Action codes of an input word.
  localparam logic [1:0] ActTick    = 2'd0;
  localparam logic [1:0] ActBreaker = 2'd1;
  localparam logic [1:0] ActTrip    = 2'd2;

  // Command values.
  localparam logic [1:0] CmdOpen      = 2'd1;
  localparam logic [1:0] CmdClose     = 2'd2;
  localparam logic [1:0] CmdTripReset = 2'd1;

  // Event codes.
  localparam logic [1:0] EvNone    = 2'd0;
  localparam logic [1:0] EvInstant = 2'd1;
  localparam logic [1:0] EvTimed   = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] RegInstPickup = 2'd0;
  localparam logic [1:0] RegTimePickup = 2'd1;
  localparam logic [1:0] RegTimeMult   = 2'd2;
  localparam logic [1:0] RegRemoteMode = 2'd3;

  // Reset values of the configuration registers.
  localparam cur_t             InstPickupReset = 20'd50000;
  localparam cur_t             TimePickupReset = 20'd5000;
  localparam logic [MultW-1:0] TimeMultReset   = 16'd15;

  typedef struct packed {
    logic [1:0] action;
    cur_t       current_a;
    cur_t       current_b;
    cur_t       current_c;
    cur_t       current_n;
    logic [1:0] command_value;
    logic       command_origin;
  } item_t;

  typedef struct packed {
    logic       breaker_closed;
    logic       trip_active;
    logic       fault_active;
    logic [1:0] fault_event;
    cur_t       shown_a;
    cur_t       shown_b;
    cur_t       shown_c;
    cur_t       shown_n;
  } result_t;

  typedef struct packed {
    cur_t             instant_pickup;
    cur_t             timed_pickup;
    logic [MultW-1:0] time_multiplier;
    logic             remote_mode;
  } cfg_t;

endpackage
`default_nettype wire

// ===== src/overcurrent_protection_relay.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Overcurrent protection relay
// Feeder relay with instantaneous and time overcurrent elements, breaker and
// trip-reset commands gated by the local/remote mode.
//
//   channel  | signals                             | word
//   ---------+-------------------------------------+-------------------
//   item     | item_valid, item_stall, item        | action and currents
//   result   | result_valid, result_stall, result  | relay status
//   config   | cfg_valid, cfg_ready, cfg_index/data| register write
//
// Commands and ticks on an open or tripped breaker set done on acceptance, and
// result_valid is registered from done. A live tick walks the four channels in
// turn: check, then for a channel in the time band divide on the 20-step shared
// divider, accumulate and compare. One word is in work at a time; item_stall
// stays high until its result has been taken. Reset is synchronous and restores
// the control state and settings, but not the current and divider data registers.
// ----------------------------------------------------------------------------
module overcurrent_protection_relay (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     item_valid,
  output logic                    item_stall,
  input  wire ocr_pkg::item_t     item,
  output logic                    result_valid,
  input  wire                     result_stall,
  output ocr_pkg::result_t        result,
  input  wire                     cfg_valid,
  output logic                    cfg_ready,
  input  wire  [1:0]              cfg_index,
  input  wire ocr_pkg::cur_t      cfg_data
);
  import ocr_pkg::*;

  cfg_t cfg;
  logic busy;
  logic done;
  logic start;

  assign cfg_ready  = 1'b1;
  assign item_stall = busy || (result_valid && result_stall);
  assign start      = item_valid && !item_stall;

  ocr_core u_core (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .cfg    (cfg),
    .busy   (busy),
    .done   (done),
    .status (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (done) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.instant_pickup  <= InstPickupReset;
      cfg.timed_pickup    <= TimePickupReset;
      cfg.time_multiplier <= TimeMultReset;
      cfg.remote_mode     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        RegInstPickup: cfg.instant_pickup  <= cfg_data;
        RegTimePickup: cfg.timed_pickup    <= cfg_data;
        RegTimeMult:   cfg.time_multiplier <= cfg_data[MultW-1:0];
        RegRemoteMode: cfg.remote_mode     <= cfg_data[0];
        default:       cfg.remote_mode     <= cfg.remote_mode;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/ocr_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Overcurrent relay divider
// Restoring divider, one quotient bit per cycle. A zero divisor gives an
// all-ones quotient.
// ----------------------------------------------------------------------------
module ocr_div (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  start,
  input  wire ocr_pkg::cur_t   dividend,
  input  wire ocr_pkg::cur_t   divisor,
  output logic                 done,
  output ocr_pkg::cur_t        quotient
);
  import ocr_pkg::*;

  localparam int CntW = $clog2(CurW);
  localparam logic [CntW-1:0] LastCnt = CntW'(CurW - 1);

  cur_t            rem;
  cur_t            quo;
  logic [CntW-1:0] cnt;
  logic            running;
  logic [CurW:0]   trial;
  logic            fits;

  assign trial    = {rem, quo[CurW-1]};
  assign fits     = trial >= {1'b0, divisor};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == LastCnt) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (running) begin
      rem <= fits ? CurW'(trial - {1'b0, divisor}) : trial[CurW-1:0];
      quo <= {quo[CurW-2:0], fits};
    end
  end

endmodule
`default_nettype wire

// ===== src/ocr_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Overcurrent relay sequencer
// Holds the relay state and walks the four channels of a tick one at a time,
// sharing a single divider for the time overcurrent quotient.
// ----------------------------------------------------------------------------
module ocr_core (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    start,
  input  wire ocr_pkg::item_t    item,
  input  wire ocr_pkg::cfg_t     cfg,
  output logic                   busy,
  output logic                   done,
  output ocr_pkg::result_t       status
);
  import ocr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_ACCUM,
    ST_COMPARE
  } state_t;

  state_t           state;
  logic [ChW-1:0]   ch;
  logic             breaker;
  logic             trip;
  logic             fault;
  logic [1:0]       event_code;
  timer_t           timer [NumCh];
  cur_t             shown [NumCh];
  cur_t             cur   [NumCh];
  logic [TimerW:0]  sum;
  logic             div_start;
  logic             div_done;
  cur_t             quotient;
  logic             last_ch;

  assign last_ch = ch == ChW'(NumCh - 1);
  assign busy    = (state != ST_IDLE) || done;

  assign status.breaker_closed = breaker;
  assign status.trip_active    = trip;
  assign status.fault_active   = fault;
  assign status.fault_event    = event_code;
  assign status.shown_a        = shown[0];
  assign status.shown_b        = shown[1];
  assign status.shown_c        = shown[2];
  assign status.shown_n        = shown[3];

  ocr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (cur[ch]),
    .divisor  (cfg.timed_pickup),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      ch         <= '0;
      done       <= 1'b0;
      div_start  <= 1'b0;
      breaker    <= 1'b0;
      trip       <= 1'b0;
      fault      <= 1'b0;
      event_code <= EvNone;
      for (int i = 0; i < NumCh; i++) begin
        timer[i] <= '0;
        shown[i] <= '0;
      end
    end else begin
      done      <= 1'b0;
      div_start <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            case (item.action)
              ActTick: begin
                fault <= 1'b0;
                if (!breaker) begin
                  for (int i = 0; i < NumCh; i++) shown[i] <= '0;
                  done <= 1'b1;
                end else if (trip) begin
                  breaker <= 1'b0;
                  for (int i = 0; i < NumCh; i++) timer[i] <= '0;
                  done <= 1'b1;
                end else begin
                  ch    <= '0;
                  state <= ST_CHECK;
                end
              end
              ActBreaker: begin
                if (item.command_origin == cfg.remote_mode) begin
                  if (item.command_value == CmdOpen) begin
                    breaker <= 1'b0;
                  end else if (item.command_value == CmdClose) begin
                    breaker <= 1'b1;
                  end
                end
                done <= 1'b1;
              end
              ActTrip: begin
                if (item.command_origin == cfg.remote_mode &&
                    item.command_value == CmdTripReset) begin
                  trip <= 1'b0;
                end
                done <= 1'b1;
              end
              default: done <= 1'b1;
            endcase
          end
        end
        ST_CHECK: begin
          shown[ch] <= cur[ch];
          if (cur[ch] >= cfg.instant_pickup) begin
            fault <= 1'b1;
            if (!trip) begin
              trip       <= 1'b1;
              event_code <= EvInstant;
            end
            if (last_ch) begin
              done  <= 1'b1;
              state <= ST_IDLE;
            end else begin
              ch <= ch + 1'b1;
            end
          end else if (cur[ch] >= cfg.timed_pickup) begin
            fault     <= 1'b1;
            div_start <= 1'b1;
            state     <= ST_DIVIDE;
          end else begin
            timer[ch] <= '0;
            if (last_ch) begin
              done  <= 1'b1;
              state <= ST_IDLE;
            end else begin
              ch <= ch + 1'b1;
            end
          end
        end
        ST_DIVIDE: begin
          if (div_done) begin
            state <= ST_ACCUM;
          end
        end
        ST_ACCUM: begin
          timer[ch] <= sum[TimerW] ? TimerMax : sum[TimerW-1:0];
          state     <= ST_COMPARE;
        end
        ST_COMPARE: begin
          if (timer[ch] > TimerW'(cfg.time_multiplier)) begin
            trip       <= 1'b1;
            event_code <= EvTimed;
          end
          if (last_ch) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end else begin
            ch    <= ch + 1'b1;
            state <= ST_CHECK;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // The currents of a tick and the timer sum carry no control meaning.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      cur[0] <= item.current_a;
      cur[1] <= item.current_b;
      cur[2] <= item.current_c;
      cur[3] <= item.current_n;
    end
    if (state == ST_DIVIDE && div_done) begin
      sum <= {1'b0, timer[ch]} + (TimerW + 1)'(quotient);
    end
  end

endmodule
`default_nettype wire

// ===== dv/ocr_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Overcurrent relay checker
// Watches the item, result and register-write channels of the relay. It keeps
// its own copy of the relay state and settings, predicts the status word for
// every accepted item, and compares each accepted result with the oldest
// prediction field by field.
// ----------------------------------------------------------------------------
module ocr_checker (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    item_valid,
  input  wire                    item_stall,
  input  wire ocr_pkg::item_t    item,
  input  wire                    result_valid,
  input  wire                    result_stall,
  input  wire ocr_pkg::result_t  result,
  input  wire                    cfg_valid,
  input  wire                    cfg_ready,
  input  wire  [1:0]             cfg_index,
  input  wire ocr_pkg::cur_t     cfg_data,
  output int                     mismatches,
  output int                     outstanding,
  output int                     words_checked,
  output int                     trips_seen
);
  import ocr_pkg::*;

  cfg_t       cfg;
  logic       breaker;
  logic       tripped;
  logic       fault;
  logic [1:0] last_ev;
  timer_t     timers [NumCh];
  cur_t       shown  [NumCh];
  result_t    status_due [$];
  result_t    want;
  int         n_err;
  int         n_checked;
  int         n_trips;

  initial begin
    n_err         = 0;
    n_checked     = 0;
    n_trips       = 0;
  end

  task automatic check_field(input string name, input cur_t expected, input cur_t actual);
    if (actual !== expected) begin
      $error("%s: expected %0d, got %0d", name, expected, actual);
      n_err++;
    end
  endtask

  // Applies one item to the relay state and queues the status word it gives.
  task automatic relay_step(input item_t w);
    cur_t            amps [NumCh];
    cur_t            quot;
    logic [TimerW:0] sum;
    logic            was_tripped;
    result_t         r;
    int              k;
    amps[0] = w.current_a;
    amps[1] = w.current_b;
    amps[2] = w.current_c;
    amps[3] = w.current_n;
    was_tripped = tripped;
    case (w.action)
      ActTick: begin
        fault = 1'b0;
        if (!breaker) begin
          for (k = 0; k < NumCh; k++) shown[k] = '0;
        end else if (tripped) begin
          // A latched trip on a closed breaker opens it; shown currents stay.
          breaker = 1'b0;
          for (k = 0; k < NumCh; k++) timers[k] = '0;
        end else begin
          for (k = 0; k < NumCh; k++) begin
            shown[k] = amps[k];
            if (amps[k] >= cfg.instant_pickup) begin
              fault = 1'b1;
              if (!tripped) begin
                tripped = 1'b1;
                last_ev = EvInstant;
              end
            end else if (amps[k] >= cfg.timed_pickup) begin
              quot = (cfg.timed_pickup == '0) ? '1 : amps[k] / cfg.timed_pickup;
              sum  = {1'b0, timers[k]} + (TimerW + 1)'(quot);
              fault = 1'b1;
              if (sum > {1'b0, TimerMax}) sum = {1'b0, TimerMax};
              timers[k] = sum[TimerW-1:0];
              // The time element overwrites the event even after a trip.
              if (sum > (TimerW + 1)'(cfg.time_multiplier)) begin
                tripped = 1'b1;
                last_ev = EvTimed;
              end
            end else begin
              timers[k] = '0;
            end
          end
        end
      end
      ActBreaker: begin
        if (w.command_origin == cfg.remote_mode) begin
          if (w.command_value == CmdOpen) breaker = 1'b0;
          else if (w.command_value == CmdClose) breaker = 1'b1;
        end
      end
      ActTrip: begin
        if (w.command_origin == cfg.remote_mode && w.command_value == CmdTripReset)
          tripped = 1'b0;
      end
      default: ;
    endcase
    if (!was_tripped && tripped) n_trips++;
    r.breaker_closed = breaker;
    r.trip_active    = tripped;
    r.fault_active   = fault;
    r.fault_event    = last_ev;
    r.shown_a        = shown[0];
    r.shown_b        = shown[1];
    r.shown_c        = shown[2];
    r.shown_n        = shown[3];
    status_due.push_back(r);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg.instant_pickup  = InstPickupReset;
      cfg.timed_pickup    = TimePickupReset;
      cfg.time_multiplier = TimeMultReset;
      cfg.remote_mode     = 1'b0;
      breaker = 1'b0;
      tripped = 1'b0;
      fault   = 1'b0;
      last_ev = EvNone;
      for (int k = 0; k < NumCh; k++) begin
        timers[k] = '0;
        shown[k]  = '0;
      end
      status_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          RegInstPickup: cfg.instant_pickup  = cfg_data;
          RegTimePickup: cfg.timed_pickup    = cfg_data;
          RegTimeMult:   cfg.time_multiplier = cfg_data[MultW-1:0];
          RegRemoteMode: cfg.remote_mode     = cfg_data[0];
          default: ;
        endcase
      end
      // A result taken on the same edge as a new item belongs to the older one.
      if (result_valid && !result_stall) begin
        if (status_due.size() == 0) begin
          $error("status word arrived with no prediction waiting");
          n_err++;
        end else begin
          want = status_due.pop_front();
          check_field("breaker_closed", cur_t'(want.breaker_closed),
                      cur_t'(result.breaker_closed));
          check_field("trip_active", cur_t'(want.trip_active), cur_t'(result.trip_active));
          check_field("fault_active", cur_t'(want.fault_active),
                      cur_t'(result.fault_active));
          check_field("fault_event", cur_t'(want.fault_event), cur_t'(result.fault_event));
          check_field("shown_a", want.shown_a, result.shown_a);
          check_field("shown_b", want.shown_b, result.shown_b);
          check_field("shown_c", want.shown_c, result.shown_c);
          check_field("shown_n", want.shown_n, result.shown_n);
          n_checked++;
        end
      end
      if (item_valid && !item_stall) relay_step(item);
    end
    mismatches    <= n_err;
    outstanding   <= status_due.size();
    words_checked <= n_checked;
    trips_seen    <= n_trips;
  end

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Overcurrent relay testbench
// Drives the relay with a short directed sequence, then with bursts of close,
// trip-reset, tick and open words or noise under several register settings,
// with random gaps and result stalls. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import ocr_pkg::*;

  localparam logic       Local     = 1'b0;
  localparam logic       Remote    = 1'b1;
  localparam logic [1:0] ActSpare  = 2'd3;
  localparam logic [1:0] CmdNone   = 2'd0;
  localparam logic [1:0] CmdSpare  = 2'd3;
  localparam int         CurMax    = (1 << CurW) - 1;
  localparam int         TailWait  = 110;
  localparam int         PerPhase  = 190;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_stall;
  item_t      item = '0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  result_t    result;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = RegInstPickup;
  cur_t       cfg_data = '0;

  int         mismatches;
  int         outstanding;
  int         words_checked;
  int         trips_seen;

  // Settings as last written, used to aim the currents and the command origin.
  cur_t        set_inst   = InstPickupReset;
  cur_t        set_timed  = TimePickupReset;
  logic        set_remote = 1'b0;
  bit          quiet      = 1'b0;
  int          sent       = 0;
  int          settings   = 1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  overcurrent_protection_relay dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  ocr_checker watch (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .item          (item),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .words_checked (words_checked),
    .trips_seen    (trips_seen)
  );

  function automatic item_t make_word(input logic [1:0] act, input cur_t a, input cur_t b,
                                      input cur_t c, input cur_t n, input logic [1:0] val,
                                      input logic origin);
    item_t w;
    w.action         = act;
    w.current_a      = a;
    w.current_b      = b;
    w.current_c      = c;
    w.current_n      = n;
    w.command_value  = val;
    w.command_origin = origin;
    return w;
  endfunction

  // Heat 0 keeps currents mostly below pickup, heat 1 favours the time band.
  function automatic cur_t pick_current(input int heat);
    int lo;
    int sel;
    lo = (set_timed < set_inst) ? set_timed : set_inst;
    case (heat)
      0:       sel = ($urandom_range(0, 9) < 8) ? 0 : $urandom_range(0, 4);
      1:       sel = ($urandom_range(0, 9) < 6) ? 1 : $urandom_range(0, 4);
      default: sel = $urandom_range(0, 4);
    endcase
    case (sel)
      0: return (lo == 0) ? cur_t'(0) : cur_t'($urandom_range(0, lo - 1));
      1: return (set_inst > set_timed) ? cur_t'($urandom_range(set_timed, set_inst - 1))
                                       : cur_t'($urandom_range(0, CurMax));
      2: return cur_t'($urandom_range(set_inst, CurMax));
      3: return cur_t'($urandom_range(0, CurMax));
      default: begin
        case ($urandom_range(0, 5))
          0:       return '0;
          1:       return '1;
          2:       return set_timed;
          3:       return set_inst;
          4:       return set_timed - 1'b1;
          default: return set_inst - 1'b1;
        endcase
      end
    endcase
  endfunction

  function automatic item_t tick_word(input int heat);
    return make_word(ActTick, pick_current(heat), pick_current(heat), pick_current(heat),
                     pick_current(heat), 2'($urandom), 1'($urandom));
  endfunction

  function automatic item_t command_word(input logic [1:0] act, input logic [1:0] val,
                                         input logic origin);
    return make_word(act, 20'($urandom), 20'($urandom), 20'($urandom), 20'($urandom),
                     val, origin);
  endfunction

  function automatic item_t noise_word();
    logic [95:0] raw;
    item_t       w;
    raw = {$urandom, $urandom, $urandom};
    w = raw[$bits(item_t)-1:0];
    return w;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send(input item_t w);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item = w;
    item_valid = 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  // Holds off new words until every predicted status word has come back.
  task automatic settle();
    item_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input cur_t data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    case (idx)
      RegInstPickup: set_inst   = data;
      RegTimePickup: set_timed  = data;
      RegRemoteMode: set_remote = data[0];
      default: ;
    endcase
  endtask

  task automatic configure(input cur_t inst, input cur_t timed, input logic [15:0] mult,
                           input logic remote);
    settle();
    write_reg(RegInstPickup, inst);
    write_reg(RegTimePickup, timed);
    write_reg(RegTimeMult, cur_t'(mult));
    write_reg(RegRemoteMode, cur_t'(remote));
    settings++;
  endtask

  // Mostly well-formed bursts (trip reset, close, a run of ticks, sometimes an open), some noise.
  task automatic run_phase(input int count);
    int made;
    int ticks;
    int heat;
    made = 0;
    while (made < count) begin
      quiet = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 4) != 0) begin
        heat  = $urandom_range(0, 2);
        ticks = $urandom_range(1, 10);
        send(command_word(ActTrip, CmdTripReset,
                          ($urandom_range(0, 9) == 0) ? !set_remote : set_remote));
        send(command_word(ActBreaker, CmdClose, set_remote));
        repeat (ticks) send(tick_word(heat));
        made += ticks + 2;
        if ($urandom_range(0, 3) == 0) begin
          send(command_word(ActBreaker, CmdOpen, set_remote));
          made++;
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send(noise_word());
          made++;
        end
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    int hold;
    forever begin
      hold = quiet ? 0 : $urandom_range(0, 5);
      if (hold > 0) begin
        result_stall = 1'b1;
        repeat (hold) @(negedge clk);
        result_stall = 1'b0;
      end
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    #30_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    repeat (4) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Reset settings: open-breaker tick, ignored commands, time and
    // instantaneous trips, the opening tick and the trip reset.
    send(make_word(ActTick, 20'd1234, 20'd50000, '1, 20'd7, CmdNone, Local));
    send(make_word(ActBreaker, '0, '0, '0, '0, CmdClose, Remote));
    send(make_word(ActBreaker, '0, '0, '0, '0, CmdNone, Local));
    send(make_word(ActBreaker, '0, '0, '0, '0, CmdSpare, Local));
    send(make_word(ActSpare, '1, '1, '1, '1, CmdClose, Local));
    send(make_word(ActBreaker, '0, '0, '0, '0, CmdClose, Local));
    send(make_word(ActTick, '0, '0, '0, '0, CmdNone, Local));
    send(make_word(ActTick, 20'd5000, 20'd4999, 20'd49999, '0, CmdNone, Local));
    send(make_word(ActTick, 20'd10000, '0, 20'd49999, 20'd49999, CmdNone, Local));
    send(make_word(ActTick, 20'd1, 20'd2, 20'd3, 20'd4, CmdNone, Local));
    send(make_word(ActTrip, '0, '0, '0, '0, CmdTripReset, Remote));
    send(make_word(ActTrip, '0, '0, '0, '0, CmdSpare, Local));
    send(make_word(ActTrip, '0, '0, '0, '0, CmdTripReset, Local));
    send(make_word(ActBreaker, '0, '0, '0, '0, CmdClose, Local));
    send(make_word(ActTick, '0, '0, 20'd49999, '0, CmdNone, Local));
    send(make_word(ActTick, 20'd50000, '1, 20'd49999, '0, CmdNone, Local));
    send(make_word(ActTick, '0, '0, '0, '0, CmdNone, Local));
    send(make_word(ActTrip, '0, '0, '0, '0, CmdTripReset, Local));
    send(make_word(ActBreaker, '0, '0, '0, '0, CmdClose, Local));
    send(make_word(ActBreaker, '0, '0, '0, '0, CmdOpen, Local));
    send(make_word(ActTick, 20'd5, 20'd6, 20'd7, 20'd8, CmdNone, Local));

    // Unit time pickup and the largest multiplier: the timer saturates
    // across trip resets, since a reset leaves the timers alone.
    configure('1, 20'd1, 16'hFFFF, Remote);
    send(make_word(ActBreaker, '0, '0, '0, '0, CmdClose, Remote));
    send(make_word(ActTick, 20'd1048574, 20'd1048574, '0, '0, CmdNone, Remote));
    send(make_word(ActTrip, '0, '0, '0, '0, CmdTripReset, Remote));
    send(make_word(ActTick, 20'd1048574, 20'd1048574, '0, '0, CmdNone, Remote));
    send(make_word(ActTrip, '0, '0, '0, '0, CmdTripReset, Remote));
    send(make_word(ActTick, 20'd1048574, 20'd1048574, '0, '0, CmdNone, Remote));

    // Zero time pickup gives the saturated quotient; zero instantaneous
    // pickup makes every current instantaneous.
    configure('1, '0, '0, Local);
    run_phase(PerPhase);
    configure('0, '0, 16'hFFFF, Remote);
    run_phase(PerPhase);
    configure('1, 20'd1, 16'hFFFF, Remote);
    run_phase(PerPhase);
    configure(InstPickupReset, TimePickupReset, TimeMultReset, Local);
    run_phase(PerPhase);
    repeat (4) begin
      cur_t        timed;
      logic [15:0] mult;
      timed = cur_t'($urandom_range(1, 100000));
      case ($urandom_range(0, 3))
        0:       mult = 16'($urandom_range(0, 20));
        1:       mult = 16'($urandom_range(0, 500));
        2:       mult = 16'($urandom_range(0, 5000));
        default: mult = 16'($urandom_range(0, 65535));
      endcase
      configure(cur_t'($urandom_range(timed, CurMax)), timed, mult, 1'($urandom));
      run_phase(PerPhase);
    end

    settle();
    repeat (TailWait) @(negedge clk);
    $display("Sent %0d words under %0d register settings; %0d status words checked.",
             sent, settings, words_checked);
    $display("Trips predicted along the way: %0d.", trips_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
src/ocr_pkg.sv
src/ocr_div.sv
src/ocr_core.sv
src/overcurrent_protection_relay.sv
dv/ocr_checker.sv
dv/testbench.sv
